FILE: rtl/cau_pkg.sv
`default_nettype none
package cau_pkg;

    localparam int DW        = 32;
    localparam int FRAC_BITS = 16;
    localparam int PW        = 2 * DW;
    localparam int SW        = PW + 1;
    localparam int NW        = PW + FRAC_BITS;
    localparam int QW        = DW;
    localparam int RSW       = DW + 3;
    localparam int OPW       = 4;

    localparam logic [OPW-1:0] OP_ADD  = 4'd0;
    localparam logic [OPW-1:0] OP_SUB  = 4'd1;
    localparam logic [OPW-1:0] OP_MUL  = 4'd2;
    localparam logic [OPW-1:0] OP_DIV  = 4'd3;
    localparam logic [OPW-1:0] OP_CONJ = 4'd4;
    localparam logic [OPW-1:0] OP_NEG  = 4'd5;
    localparam logic [OPW-1:0] OP_MAG  = 4'd6;
    localparam logic [OPW-1:0] OP_EQ   = 4'd7;
    localparam logic [OPW-1:0] OP_NE   = 4'd8;

    localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic [DW-1:0] re;
        logic [DW-1:0] im;
        logic          flag;
    } t_res;

    typedef struct packed {
        logic neg_re;
        logic neg_im;
        logic ovf_re;
        logic ovf_im;
        logic dz;
    } t_div_ctl;

    typedef struct packed {
        logic          flag;
        logic [DW-1:0] val;
    } t_sat;

    // sign and magnitude to saturated two's complement
    function automatic t_sat sat_sm(input logic neg, input logic [PW-1:0] mag);
        t_sat          r;
        logic [PW-1:0] lim_p;
        logic [PW-1:0] lim_n;
        lim_p = {{(PW-DW){1'b0}}, MAXV};
        lim_n = lim_p + 1'b1;
        r     = '0;
        if (neg) begin
            if (mag > lim_n) begin
                r.flag = 1'b1;
                r.val  = MINV;
            end else begin
                r.val = {DW{1'b0}} - mag[DW-1:0];
            end
        end else begin
            if (mag > lim_p) begin
                r.flag = 1'b1;
                r.val  = MAXV;
            end else begin
                r.val = mag[DW-1:0];
            end
        end
        return r;
    endfunction

    function automatic t_sat sat_wide(input logic [DW:0] s);
        t_sat r;
        r = '0;
        if (s[DW] != s[DW-1]) begin
            r.flag = 1'b1;
            r.val  = s[DW] ? MINV : MAXV;
        end else begin
            r.val = s[DW-1:0];
        end
        return r;
    endfunction

    function automatic logic [PW-1:0] abs_mag(input logic [SW-1:0] s);
        logic [SW-1:0] t;
        t = s[SW-1] ? ({SW{1'b0}} - s) : s;
        return t[PW-1:0];
    endfunction

    // ops that finish in the products stage of the top
    function automatic t_res simple_op(input logic [OPW-1:0] op,
                                       input logic [DW-1:0] ar, input logic [DW-1:0] ai,
                                       input logic [DW-1:0] br, input logic [DW-1:0] bi);
        t_res r;
        t_sat sr;
        t_sat si;
        r  = '0;
        sr = '0;
        si = '0;
        case (op)
            OP_ADD: begin
                sr     = sat_wide({ar[DW-1], ar} + {br[DW-1], br});
                si     = sat_wide({ai[DW-1], ai} + {bi[DW-1], bi});
                r.re   = sr.val;
                r.im   = si.val;
                r.flag = sr.flag | si.flag;
            end
            OP_SUB: begin
                sr     = sat_wide({ar[DW-1], ar} - {br[DW-1], br});
                si     = sat_wide({ai[DW-1], ai} - {bi[DW-1], bi});
                r.re   = sr.val;
                r.im   = si.val;
                r.flag = sr.flag | si.flag;
            end
            OP_CONJ: begin
                si     = sat_wide({(DW+1){1'b0}} - {ai[DW-1], ai});
                r.re   = ar;
                r.im   = si.val;
                r.flag = si.flag;
            end
            OP_NEG: begin
                sr     = sat_wide({(DW+1){1'b0}} - {ar[DW-1], ar});
                si     = sat_wide({(DW+1){1'b0}} - {ai[DW-1], ai});
                r.re   = sr.val;
                r.im   = si.val;
                r.flag = sr.flag | si.flag;
            end
            OP_EQ: begin
                r.flag = (ar == br) && (ai == bi);
            end
            OP_NE: begin
                r.flag = (ar != br) || (ai != bi);
            end
            default: begin
                r = '0;
            end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/cau_div.sv
`default_nettype none
module cau_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic [cau_pkg::PW-1:0]   i_num_re,
    input  wire logic [cau_pkg::PW-1:0]   i_num_im,
    input  wire logic [cau_pkg::PW-1:0]   i_den,
    input  wire cau_pkg::t_div_ctl        i_ctl,
    output logic      [cau_pkg::QW-1:0]   o_q_re,
    output logic      [cau_pkg::QW-1:0]   o_q_im,
    output cau_pkg::t_div_ctl             o_ctl
);

    localparam int PW = cau_pkg::PW;
    localparam int QW = cau_pkg::QW;
    localparam int NW = cau_pkg::NW;

    logic [PW-1:0]     r_rem_re [0:QW];
    logic [PW-1:0]     r_rem_im [0:QW];
    logic [QW-1:0]     r_lo_re  [0:QW];
    logic [QW-1:0]     r_lo_im  [0:QW];
    logic [QW-1:0]     r_q_re   [0:QW];
    logic [QW-1:0]     r_q_im   [0:QW];
    logic [PW-1:0]     r_den    [0:QW];
    cau_pkg::t_div_ctl r_ctl    [0:QW];

    logic [NW-1:0]     n_sh_re;
    logic [NW-1:0]     n_sh_im;
    logic [PW-1:0]     n_hi_re;
    logic [PW-1:0]     n_hi_im;
    cau_pkg::t_div_ctl n_ctl;

    // numerator scaled by the fraction bits; quotient fits the word only if hi < den
    always_comb begin
        n_sh_re      = NW'(i_num_re) << cau_pkg::FRAC_BITS;
        n_sh_im      = NW'(i_num_im) << cau_pkg::FRAC_BITS;
        n_hi_re      = PW'(n_sh_re[NW-1:QW]);
        n_hi_im      = PW'(n_sh_im[NW-1:QW]);
        n_ctl        = i_ctl;
        n_ctl.ovf_re = (n_hi_re >= i_den);
        n_ctl.ovf_im = (n_hi_im >= i_den);
        n_ctl.dz     = (i_den == {PW{1'b0}});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_re[0] <= n_hi_re;
            r_rem_im[0] <= n_hi_im;
            r_lo_re[0]  <= n_sh_re[QW-1:0];
            r_lo_im[0]  <= n_sh_im[QW-1:0];
            r_q_re[0]   <= {QW{1'b0}};
            r_q_im[0]   <= {QW{1'b0}};
            r_den[0]    <= i_den;
            r_ctl[0]    <= n_ctl;
        end
    end

    // one quotient bit per stage, msb first
    for (genvar s = 0; s < QW; s++) begin : g_step
        logic [PW:0] n_t_re;
        logic [PW:0] n_t_im;
        logic [PW:0] n_d_re;
        logic [PW:0] n_d_im;
        logic        n_ge_re;
        logic        n_ge_im;

        always_comb begin
            n_t_re  = {r_rem_re[s], r_lo_re[s][QW-1]};
            n_t_im  = {r_rem_im[s], r_lo_im[s][QW-1]};
            n_d_re  = n_t_re - {1'b0, r_den[s]};
            n_d_im  = n_t_im - {1'b0, r_den[s]};
            n_ge_re = (n_t_re >= {1'b0, r_den[s]});
            n_ge_im = (n_t_im >= {1'b0, r_den[s]});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_re[s+1] <= n_ge_re ? n_d_re[PW-1:0] : n_t_re[PW-1:0];
                r_rem_im[s+1] <= n_ge_im ? n_d_im[PW-1:0] : n_t_im[PW-1:0];
                r_q_re[s+1]   <= {r_q_re[s][QW-2:0], n_ge_re};
                r_q_im[s+1]   <= {r_q_im[s][QW-2:0], n_ge_im};
                r_lo_re[s+1]  <= r_lo_re[s] << 1;
                r_lo_im[s+1]  <= r_lo_im[s] << 1;
                r_den[s+1]    <= r_den[s];
                r_ctl[s+1]    <= r_ctl[s];
            end
        end
    end

    assign o_q_re = r_q_re[QW];
    assign o_q_im = r_q_im[QW];
    assign o_ctl  = r_ctl[QW];

endmodule
`default_nettype wire

FILE: rtl/cau_sqrt.sv
`default_nettype none
module cau_sqrt (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic [cau_pkg::PW-1:0] i_val,
    output logic      [cau_pkg::QW-1:0] o_root
);

    localparam int PW  = cau_pkg::PW;
    localparam int QW  = cau_pkg::QW;
    localparam int RSW = cau_pkg::RSW;

    logic [PW-1:0]  r_val  [0:QW];
    logic [RSW-1:0] r_rem  [0:QW];
    logic [QW-1:0]  r_root [0:QW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val[0]  <= i_val;
            r_rem[0]  <= {RSW{1'b0}};
            r_root[0] <= {QW{1'b0}};
        end
    end

    // one root bit per stage from the top pair of input bits
    for (genvar s = 0; s < QW; s++) begin : g_step
        logic [RSW-1:0] n_t;
        logic [RSW-1:0] n_trial;
        logic           n_ge;

        always_comb begin
            n_t     = {r_rem[s][RSW-3:0], r_val[s][PW-1 -: 2]};
            n_trial = RSW'({r_root[s], 2'b01});
            n_ge    = (n_t >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1]  <= n_ge ? (n_t - n_trial) : n_t;
                r_root[s+1] <= {r_root[s][QW-2:0], n_ge};
                r_val[s+1]  <= r_val[s] << 2;
            end
        end
    end

    assign o_root = r_root[QW];

endmodule
`default_nettype wire

FILE: rtl/complex_arith_unit_top.sv
// complex fixed point alu, one word in and one word out per cycle when not stalled
// depth: 38 register stages, from the input word register to the output register r_out
// throughput: one word per cycle when not stalled; depth is set by the 32 stage divider and root pipelines
// a stalled output freezes the whole pipe; ready follows output ready and output valid
// reset (i_rst_n low, synchronous) clears all valid bits; data registers are not reset
`default_nettype none
module complex_arith_unit_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  wire logic [4*cau_pkg::DW-1:0]    i_s_axis_tdata,  // a_re, a_im, b_re, b_im
    input  wire logic [cau_pkg::OPW-1:0]     i_s_axis_tuser,  // req_type
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    output logic      [2*cau_pkg::DW-1:0]    o_m_axis_tdata,  // res_re, res_im
    output logic                             o_m_axis_tuser   // flag
);

    localparam int DW  = cau_pkg::DW;
    localparam int PW  = cau_pkg::PW;
    localparam int SW  = cau_pkg::SW;
    localparam int QW  = cau_pkg::QW;
    localparam int OPW = cau_pkg::OPW;
    localparam int LAT = QW + 6;

    logic           en;
    logic [LAT-1:0] r_vld;

    // stage 1: input word
    logic [OPW-1:0] r1_op;
    logic [DW-1:0]  r1_ar, r1_ai, r1_br, r1_bi;

    // stage 2: products
    logic [OPW-1:0]        r2_op;
    cau_pkg::t_res         r2_simp;
    logic signed [PW-1:0]  r2_p_rr, r2_p_ii, r2_p_ri, r2_p_ir, r2_sq_x, r2_sq_y;
    logic signed [DW-1:0]  n_x, n_y;

    // stage 3: sums
    logic [OPW-1:0] r3_op;
    cau_pkg::t_res  r3_simp;
    logic [SW-1:0]  r3_m_re, r3_m_im, r3_d_re, r3_d_im;
    logic [PW-1:0]  r3_sq;

    // stage 4: magnitudes
    logic [OPW-1:0]    r4_op;
    cau_pkg::t_res     r4_simp;
    logic [PW-1:0]     r4_m_re, r4_m_im, r4_d_re, r4_d_im, r4_sq;
    logic              r4_mn_re, r4_mn_im;
    cau_pkg::t_div_ctl r4_dctl;

    // stage 5 onward: delay line beside the divider and root pipes
    logic [OPW-1:0] r_dop  [0:QW];
    cau_pkg::t_res  r_dfin [0:QW];
    cau_pkg::t_res  n_fin;
    cau_pkg::t_sat  n_mr, n_mi;

    logic [QW-1:0]     q_re, q_im, root;
    cau_pkg::t_div_ctl dctl;

    cau_pkg::t_res r_out;
    cau_pkg::t_res n_out;
    cau_pkg::t_sat n_sr, n_si, n_sm;

    assign en              = ~r_vld[LAT-1] | i_m_axis_tready;
    assign o_s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op <= i_s_axis_tuser;
            r1_ar <= i_s_axis_tdata[DW-1:0];
            r1_ai <= i_s_axis_tdata[2*DW-1:DW];
            r1_br <= i_s_axis_tdata[3*DW-1:2*DW];
            r1_bi <= i_s_axis_tdata[4*DW-1:3*DW];
        end
    end

    // squares use a for magnitude and b for the divide denominator
    always_comb begin
        n_x = (r1_op == cau_pkg::OP_MAG) ? $signed(r1_ar) : $signed(r1_br);
        n_y = (r1_op == cau_pkg::OP_MAG) ? $signed(r1_ai) : $signed(r1_bi);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_op   <= r1_op;
            r2_simp <= cau_pkg::simple_op(r1_op, r1_ar, r1_ai, r1_br, r1_bi);
            r2_p_rr <= $signed(r1_ar) * $signed(r1_br);
            r2_p_ii <= $signed(r1_ai) * $signed(r1_bi);
            r2_p_ri <= $signed(r1_ar) * $signed(r1_bi);
            r2_p_ir <= $signed(r1_ai) * $signed(r1_br);
            r2_sq_x <= n_x * n_x;
            r2_sq_y <= n_y * n_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_op   <= r2_op;
            r3_simp <= r2_simp;
            r3_m_re <= SW'(r2_p_rr) - SW'(r2_p_ii);
            r3_m_im <= SW'(r2_p_ri) + SW'(r2_p_ir);
            r3_d_re <= SW'(r2_p_rr) + SW'(r2_p_ii);
            r3_d_im <= SW'(r2_p_ir) - SW'(r2_p_ri);
            r3_sq   <= $unsigned(r2_sq_x) + $unsigned(r2_sq_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_op    <= r3_op;
            r4_simp  <= r3_simp;
            r4_m_re  <= cau_pkg::abs_mag(r3_m_re);
            r4_m_im  <= cau_pkg::abs_mag(r3_m_im);
            r4_mn_re <= r3_m_re[SW-1];
            r4_mn_im <= r3_m_im[SW-1];
            r4_d_re  <= cau_pkg::abs_mag(r3_d_re);
            r4_d_im  <= cau_pkg::abs_mag(r3_d_im);
            // numerator signs; the divider fills in the overflow and zero bits
            r4_dctl  <= {r3_d_re[SW-1], r3_d_im[SW-1], 3'b000};
            r4_sq    <= r3_sq;
        end
    end

    // product truncated toward zero, then saturated
    always_comb begin
        n_mr = cau_pkg::sat_sm(r4_mn_re, r4_m_re >> cau_pkg::FRAC_BITS);
        n_mi = cau_pkg::sat_sm(r4_mn_im, r4_m_im >> cau_pkg::FRAC_BITS);
        if (r4_op == cau_pkg::OP_MUL) begin
            n_fin.re   = n_mr.val;
            n_fin.im   = n_mi.val;
            n_fin.flag = n_mr.flag | n_mi.flag;
        end else begin
            n_fin = r4_simp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dop[0]  <= r4_op;
            r_dfin[0] <= n_fin;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dop[k+1]  <= r_dop[k];
                r_dfin[k+1] <= r_dfin[k];
            end
        end
    end

    cau_div u_div (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_num_re (r4_d_re),
        .i_num_im (r4_d_im),
        .i_den    (r4_sq),
        .i_ctl    (r4_dctl),
        .o_q_re   (q_re),
        .o_q_im   (q_im),
        .o_ctl    (dctl)
    );

    cau_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (r4_sq),
        .o_root (root)
    );

    always_comb begin
        n_sr  = cau_pkg::sat_sm(dctl.neg_re, dctl.ovf_re ? {PW{1'b1}} : PW'(q_re));
        n_si  = cau_pkg::sat_sm(dctl.neg_im, dctl.ovf_im ? {PW{1'b1}} : PW'(q_im));
        n_sm  = cau_pkg::sat_sm(1'b0, PW'(root));
        n_out = r_dfin[QW];
        case (r_dop[QW])
            cau_pkg::OP_DIV: begin
                if (dctl.dz) begin
                    n_out.re   = cau_pkg::MAXV;
                    n_out.im   = cau_pkg::MAXV;
                    n_out.flag = 1'b1;
                end else begin
                    n_out.re   = n_sr.val;
                    n_out.im   = n_si.val;
                    n_out.flag = n_sr.flag | n_si.flag;
                end
            end
            cau_pkg::OP_MAG: begin
                n_out.re   = n_sm.val;
                n_out.im   = {DW{1'b0}};
                n_out.flag = n_sm.flag;
            end
            default: begin
                n_out = r_dfin[QW];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_vld[LAT-1];
    assign o_m_axis_tdata  = {r_out.im, r_out.re};
    assign o_m_axis_tuser  = r_out.flag;

endmodule
`default_nettype wire
